### sv/htc_pkg.sv
package htc_pkg;

  // Fixed widths of the request and result fields.
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 16;
  localparam int PRE_W    = 6;
  localparam int CAP_W    = 13;
  localparam int MODE_W   = 2;
  localparam int OC_W     = 2;
  localparam int CFG_IDX_W = 3;

  // History ring, capture limit and command queue sizes.
  localparam int PRE_DEPTH   = 32;
  localparam int MAX_CAPTURE = 4096;
  localparam int RING_W      = $clog2(PRE_DEPTH);
  localparam int SUM_W       = RING_W + 2;
  localparam int TAKE_W      = $clog2(PRE_DEPTH + 2);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam logic [INDEX_W-1:0]  INDEX_MAX  = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRETRIG = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE = 3'd5;

  // Edge mode codes.
  localparam logic [MODE_W-1:0] EDGE_RISE   = 2'd0;
  localparam logic [MODE_W-1:0] EDGE_FALL   = 2'd1;
  localparam logic [MODE_W-1:0] EDGE_EITHER = 2'd2;

  // Outcome codes.
  localparam logic [OC_W-1:0] OUT_OK      = 2'd0;
  localparam logic [OC_W-1:0] OUT_NOTRIG  = 2'd1;
  localparam logic [OC_W-1:0] OUT_INVALID = 2'd2;
  localparam logic [OC_W-1:0] OUT_INSUF   = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] trigger_level;
    logic [SAMPLE_W-1:0] hysteresis_width;
    logic [MODE_W-1:0]   edge_mode;
    logic [INDEX_W-1:0]  search_offset;
    logic [PRE_W-1:0]    pretrigger_length;
    logic [CAP_W-1:0]    capture_length;
  } cfg_t;

  // What the back end does with one queued request.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EMIT  = 2'd1,
    CMD_BURST = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [SAMPLE_W-1:0] sample;
    logic                emit_sample;
    logic [INDEX_W-1:0]  pos;
    logic [OC_W-1:0]     outcome;
    logic                end_flag;
    logic [PRE_W-1:0]    pre;
    logic [TAKE_W-1:0]   take;
  } cmd_t;

endpackage

### sv/htc_front.sv
module htc_front import htc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample_value,
  input  logic                record_first,
  input  logic                record_last,
  output logic                push,
  output cmd_t                push_cmd,
  input  logic                queue_full
);

  typedef enum logic [3:0] {
    PH_WAIT    = 4'b0001,
    PH_SEARCH  = 4'b0010,
    PH_CAPTURE = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  phase_t             phase, phase_next;
  logic [INDEX_W-1:0] record_index, record_index_next;
  logic               rise_armed, rise_armed_next;
  logic               fall_armed, fall_armed_next;
  logic [CAP_W-1:0]   samples_remaining, samples_remaining_next;
  logic [INDEX_W-1:0] found_position, found_position_next;

  logic               accept;
  phase_t             ph;
  logic [INDEX_W-1:0] idx;
  logic               ra, fa;
  logic [CAP_W-1:0]   rem, rem_dec;
  logic [INDEX_W-1:0] fpos;
  logic [SAMPLE_W-1:0] band_lo, band_hi;
  logic [SAMPLE_W:0]  hi_sum;
  logic               at_lo, at_hi;
  logic               rise_hit, fall_hit, trig;
  logic [CAP_W-1:0]   len;
  logic [CAP_W-1:0]   pre_plus;
  logic [CAP_W-1:0]   take;

  assign in_stall = queue_full;
  assign accept   = in_valid & ~queue_full;

  // A record start restarts the search state for this sample.
  assign ph   = record_first ? PH_WAIT : phase;
  assign idx  = record_first ? '0 : record_index;
  assign ra   = record_first ? 1'b0 : rise_armed;
  assign fa   = record_first ? 1'b0 : fall_armed;
  assign rem  = record_first ? '0 : samples_remaining;
  assign fpos = record_first ? '0 : found_position;

  // Hysteresis band, clamped at both ends of the sample range.
  assign band_lo = (cfg.trigger_level > cfg.hysteresis_width) ?
                   cfg.trigger_level - cfg.hysteresis_width : '0;
  assign hi_sum  = {1'b0, cfg.trigger_level} + {1'b0, cfg.hysteresis_width};
  assign band_hi = hi_sum[SAMPLE_W] ? SAMPLE_MAX : hi_sum[SAMPLE_W-1:0];
  assign at_lo   = sample_value <= band_lo;
  assign at_hi   = sample_value >= band_hi;

  // Trigger test uses the arming held before this sample.
  assign rise_hit = ra & at_hi;
  assign fall_hit = fa & at_lo;

  always_comb begin
    case (cfg.edge_mode)
      EDGE_RISE:   trig = rise_hit;
      EDGE_FALL:   trig = fall_hit;
      EDGE_EITHER: trig = rise_hit | fall_hit;
      default:     trig = 1'b0;
    endcase
  end

  // Window length and the part of it emitted at the trigger.
  assign len      = (cfg.capture_length > CAP_W'(MAX_CAPTURE)) ?
                    CAP_W'(MAX_CAPTURE) : cfg.capture_length;
  assign pre_plus = CAP_W'(cfg.pretrigger_length) + CAP_W'(1);
  assign take     = (len < pre_plus) ? len : pre_plus;
  assign rem_dec  = (rem != '0) ? rem - CAP_W'(1) : rem;

  // Phase sequencing and request classification.
  always_comb begin
    phase_next             = ph;
    record_index_next      = idx;
    rise_armed_next        = ra;
    fall_armed_next        = fa;
    samples_remaining_next = rem;
    found_position_next    = fpos;
    push                   = 1'b0;
    push_cmd.kind          = CMD_WRITE;
    push_cmd.sample        = sample_value;
    push_cmd.emit_sample   = 1'b0;
    push_cmd.pos           = '0;
    push_cmd.outcome       = OUT_OK;
    push_cmd.end_flag      = 1'b0;
    push_cmd.pre           = cfg.pretrigger_length;
    push_cmd.take          = take[TAKE_W-1:0];

    if (ph != PH_DONE) begin
      push              = accept;
      record_index_next = (idx == INDEX_MAX) ? idx : idx + INDEX_W'(1);
    end

    unique case (ph)
      PH_WAIT: begin
        if (idx == cfg.search_offset) begin
          rise_armed_next = at_lo;
          fall_armed_next = at_hi;
          phase_next      = PH_SEARCH;
        end
        if (record_last) begin
          push_cmd.kind     = CMD_EMIT;
          push_cmd.outcome  = OUT_INVALID;
          push_cmd.end_flag = 1'b1;
          phase_next        = PH_DONE;
        end
      end
      PH_SEARCH: begin
        rise_armed_next = ra | at_lo;
        fall_armed_next = fa | at_hi;
        if (trig) begin
          found_position_next = idx;
          if ((len == '0) || (cfg.pretrigger_length > PRE_W'(PRE_DEPTH)) ||
              (INDEX_W'(cfg.pretrigger_length) > idx)) begin
            push_cmd.kind     = CMD_EMIT;
            push_cmd.pos      = idx;
            push_cmd.outcome  = OUT_INVALID;
            push_cmd.end_flag = 1'b1;
            phase_next        = PH_DONE;
          end else begin
            push_cmd.kind = CMD_BURST;
            push_cmd.pos  = idx;
            if (take == len) begin
              push_cmd.end_flag = 1'b1;
              phase_next        = PH_DONE;
            end else begin
              samples_remaining_next = len - take;
              if (record_last) begin
                push_cmd.outcome  = OUT_INSUF;
                push_cmd.end_flag = 1'b1;
                phase_next        = PH_DONE;
              end else begin
                phase_next = PH_CAPTURE;
              end
            end
          end
        end else if (record_last) begin
          push_cmd.kind     = CMD_EMIT;
          push_cmd.outcome  = OUT_NOTRIG;
          push_cmd.end_flag = 1'b1;
          phase_next        = PH_DONE;
        end
      end
      PH_CAPTURE: begin
        samples_remaining_next = rem_dec;
        push_cmd.kind          = CMD_EMIT;
        push_cmd.emit_sample   = 1'b1;
        push_cmd.pos           = fpos;
        if (rem_dec == '0) begin
          push_cmd.end_flag = 1'b1;
          phase_next        = PH_DONE;
        end else if (record_last) begin
          push_cmd.outcome  = OUT_INSUF;
          push_cmd.end_flag = 1'b1;
          phase_next        = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  // State update on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_WAIT;
      record_index      <= '0;
      rise_armed        <= 1'b0;
      fall_armed        <= 1'b0;
      samples_remaining <= '0;
      found_position    <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      record_index      <= record_index_next;
      rise_armed        <= rise_armed_next;
      fall_armed        <= fall_armed_next;
      samples_remaining <= samples_remaining_next;
      found_position    <= found_position_next;
    end
  end

endmodule

### sv/htc_queue.sv
module htc_queue import htc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### sv/htc_back.sv
module htc_back import htc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  cmd_t                head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] captured_sample,
  output logic [INDEX_W-1:0]  trigger_position,
  output logic [OC_W-1:0]     outcome,
  output logic                end_of_run
);

  typedef enum logic [1:0] {
    BK_IDLE  = 2'b01,
    BK_BURST = 2'b10
  } bk_state_t;

  bk_state_t           state, state_next;
  logic [TAKE_W-1:0]   elem, elem_next;
  logic [SAMPLE_W-1:0] ring [PRE_DEPTH];
  logic [RING_W-1:0]   ring_pointer;
  logic [SAMPLE_W-1:0] rd_data;

  logic                out_load;
  logic                out_set;
  logic [SAMPLE_W-1:0] res_sample;
  logic [INDEX_W-1:0]  res_pos;
  logic [OC_W-1:0]     res_outcome;
  logic                res_end;
  logic                wr_en;
  logic                rd_en;
  logic [TAKE_W-1:0]   rd_elem;
  logic [TAKE_W-1:0]   elem_inc;
  logic [SUM_W-1:0]    addr_sum;
  logic [RING_W-1:0]   rd_addr;
  logic                elem_last;
  logic                elem_hist;

  assign out_load  = ~out_valid | ~out_stall;
  assign elem_inc  = elem + TAKE_W'(1);
  assign elem_last = elem_inc == head_cmd.take;
  assign elem_hist = TAKE_W'(head_cmd.pre) > elem;
  assign rd_elem   = (state == BK_IDLE) ? '0 : elem_inc;

  // Ring slot of a window element: pointer minus pretrigger plus element.
  assign addr_sum = SUM_W'(ring_pointer) + SUM_W'(PRE_DEPTH) - SUM_W'(head_cmd.pre) +
                    SUM_W'(rd_elem);
  assign rd_addr  = (addr_sum >= SUM_W'(PRE_DEPTH)) ?
                    RING_W'(addr_sum - SUM_W'(PRE_DEPTH)) : RING_W'(addr_sum);

  // Request execution and result formation.
  always_comb begin
    state_next  = state;
    elem_next   = elem;
    pop         = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    out_set     = 1'b0;
    res_sample  = '0;
    res_pos     = head_cmd.pos;
    res_outcome = head_cmd.outcome;
    res_end     = head_cmd.end_flag;

    unique case (state)
      BK_IDLE: begin
        if (head_valid) begin
          unique case (head_cmd.kind)
            CMD_WRITE: begin
              wr_en = 1'b1;
              pop   = 1'b1;
            end
            CMD_EMIT: begin
              if (out_load) begin
                out_set    = 1'b1;
                res_sample = head_cmd.emit_sample ? head_cmd.sample : '0;
                wr_en      = 1'b1;
                pop        = 1'b1;
              end
            end
            CMD_BURST: begin
              elem_next  = '0;
              state_next = BK_BURST;
              rd_en      = head_cmd.pre != '0;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      BK_BURST: begin
        if (out_load) begin
          out_set     = 1'b1;
          res_sample  = elem_hist ? rd_data : head_cmd.sample;
          res_outcome = elem_last ? head_cmd.outcome : OUT_OK;
          res_end     = elem_last & head_cmd.end_flag;
          if (elem_last) begin
            wr_en      = 1'b1;
            pop        = 1'b1;
            state_next = BK_IDLE;
          end else begin
            elem_next = elem_inc;
            rd_en     = TAKE_W'(head_cmd.pre) > elem_inc;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // History ring: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[ring_pointer] <= head_cmd.sample;
    end
    if (rd_en) begin
      rd_data <= ring[rd_addr];
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (out_set) begin
      captured_sample  <= res_sample;
      trigger_position <= res_pos;
      outcome          <= res_outcome;
      end_of_run       <= res_end;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      elem         <= '0;
      ring_pointer <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      elem  <= elem_next;
      if (wr_en) begin
        ring_pointer <= (ring_pointer == RING_W'(PRE_DEPTH - 1)) ?
                        '0 : ring_pointer + RING_W'(1);
      end
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/hysteresis_trigger_capture.sv
// Hysteresis edge trigger with pretrigger capture. Samples of a record
// stream in one per cycle; each accepted sample is classified at once and,
// until its run has ended, leaves a request in a four-entry queue, so the
// input is stalled only when that queue is full. At a trigger with
// pretrigger length p the window start, min(capture_length, p + 1) results,
// is sent from the history ring and then the trigger sample at one result
// per cycle while the output is not stalled, through the ring's single read
// port, once the first history entry is fetched; later window samples
// follow one per input sample. Results leave through an output register, so
// requests that only write the history ring keep draining while a result
// waits on a stall. The ring needs no clearing after reset: only entries
// written in the current record are ever read.
module hysteresis_trigger_capture import htc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  sample_value,
  input  logic                 record_first,
  input  logic                 record_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SAMPLE_W-1:0]  captured_sample,
  output logic [INDEX_W-1:0]   trigger_position,
  output logic [OC_W-1:0]      outcome,
  output logic                 end_of_run
);

  cfg_t cfg;
  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_level     <= 16'd32768;
      cfg.hysteresis_width  <= '0;
      cfg.edge_mode         <= EDGE_RISE;
      cfg.search_offset     <= '0;
      cfg.pretrigger_length <= '0;
      cfg.capture_length    <= 13'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEVEL:   cfg.trigger_level     <= cfg_data;
        REG_HYST:    cfg.hysteresis_width  <= cfg_data;
        REG_MODE:    cfg.edge_mode         <= cfg_data[MODE_W-1:0];
        REG_OFFSET:  cfg.search_offset     <= cfg_data[INDEX_W-1:0];
        REG_PRETRIG: cfg.pretrigger_length <= cfg_data[PRE_W-1:0];
        REG_CAPTURE: cfg.capture_length    <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: trigger search and request classification.
  htc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_value (sample_value),
    .record_first (record_first),
    .record_last  (record_last),
    .push         (push),
    .push_cmd     (push_cmd),
    .queue_full   (queue_full)
  );

  // Request queue between the two halves.
  htc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: history ring and result output.
  htc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head_cmd         (head_cmd),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .captured_sample  (captured_sample),
    .trigger_position (trigger_position),
    .outcome          (outcome),
    .end_of_run       (end_of_run)
  );

endmodule

### tb/hysteresis_trigger_capture_test.sv
`timescale 1ns / 1ps

module hysteresis_trigger_capture_test;
  import htc_pkg::*;

  // Edge mode code that the block accepts but never fires on.
  localparam logic [MODE_W-1:0] EDGE_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PRINT_CAP     = 40;
  localparam int PHASE_SAMPLES = 70;

  // One captured-window result as it leaves the block.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]  position;
    logic [OC_W-1:0]     code;
    logic                run_end;
  } window_item_t;

  typedef enum logic [1:0] {
    AWAIT_ARM = 2'd0,
    SEARCHING = 2'd1,
    CAPTURING = 2'd2,
    FINISHED  = 2'd3
  } scan_phase_t;

  // Tracks the trigger search and the capture window, and holds the
  // window samples still owed by the block.
  class capture_checker;
    logic [SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0] hyst;
    logic [MODE_W-1:0]   mode;
    logic [INDEX_W-1:0]  arm_index;
    logic [PRE_W-1:0]    pre_len;
    logic [CAP_W-1:0]    cap_len;

    logic [INDEX_W-1:0]  rec_index;
    logic [INDEX_W-1:0]  trig_index;
    logic                rise_ready;
    logic                fall_ready;
    scan_phase_t         scan;
    logic [CAP_W-1:0]    left;
    logic [SAMPLE_W-1:0] history [PRE_DEPTH];
    logic [RING_W-1:0]   wr_ptr;

    window_item_t due[$];
    int errors;
    int checked;
    int samples_taken;
    int outcome_count [4];

    function new();
      level      = 16'd32768;
      hyst       = '0;
      mode       = EDGE_RISE;
      arm_index  = '0;
      pre_len    = '0;
      cap_len    = 13'd256;
      rec_index  = '0;
      trig_index = '0;
      rise_ready = 1'b0;
      fall_ready = 1'b0;
      scan       = AWAIT_ARM;
      left       = '0;
      wr_ptr     = '0;
      foreach (history[k]) history[k] = '0;
      foreach (outcome_count[k]) outcome_count[k] = 0;
      errors = 0;
      checked = 0;
      samples_taken = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
      case (idx)
        REG_LEVEL:   level = data;
        REG_HYST:    hyst = data;
        REG_MODE:    mode = data[MODE_W-1:0];
        REG_OFFSET:  arm_index = data;
        REG_PRETRIG: pre_len = data[PRE_W-1:0];
        REG_CAPTURE: cap_len = data[CAP_W-1:0];
        default: ;
      endcase
    endfunction

    // Low band floors at zero, high band saturates at full scale.
    function void band(output logic [SAMPLE_W-1:0] lo, output logic [SAMPLE_W-1:0] hi);
      logic [SAMPLE_W:0] sum;
      sum = {1'b0, level} + {1'b0, hyst};
      lo = (level > hyst) ? level - hyst : '0;
      hi = sum[SAMPLE_W] ? SAMPLE_MAX : sum[SAMPLE_W-1:0];
    endfunction

    function void add_due(logic [SAMPLE_W-1:0] smp, logic [INDEX_W-1:0] pos,
                          logic [OC_W-1:0] code, logic fin);
      window_item_t item;
      item.sample = smp;
      item.position = pos;
      item.code = code;
      item.run_end = fin;
      due.push_back(item);
      if (fin) outcome_count[code]++;
    endfunction

    // Advances the search by one accepted sample request. Returns zero when
    // the block ignores the sample because its run has already ended.
    function bit take_sample(logic [SAMPLE_W-1:0] s, logic first, logic last);
      logic [SAMPLE_W-1:0] lo, hi;
      logic rise_hit, fall_hit, fire, fin;
      logic [OC_W-1:0] tail_code;
      int win_len, take, slot;
      samples_taken++;
      if (first) begin
        rec_index = '0;
        scan = AWAIT_ARM;
        rise_ready = 1'b0;
        fall_ready = 1'b0;
        left = '0;
        trig_index = '0;
      end
      if (scan == FINISHED) return 1'b0;
      band(lo, hi);
      case (scan)
        AWAIT_ARM: begin
          if (rec_index == arm_index) begin
            rise_ready = (s <= lo);
            fall_ready = (s >= hi);
            scan = SEARCHING;
          end
          if (last) begin
            add_due('0, '0, OUT_INVALID, 1'b1);
            scan = FINISHED;
          end
        end
        SEARCHING: begin
          // The trigger test uses the arming held before this sample.
          rise_hit = rise_ready && (s >= hi);
          fall_hit = fall_ready && (s <= lo);
          if (s <= lo) rise_ready = 1'b1;
          if (s >= hi) fall_ready = 1'b1;
          fire = (mode == EDGE_RISE && rise_hit) || (mode == EDGE_FALL && fall_hit) ||
                 (mode == EDGE_EITHER && (rise_hit || fall_hit));
          if (fire) begin
            win_len = (cap_len > MAX_CAPTURE) ? MAX_CAPTURE : int'(cap_len);
            trig_index = rec_index;
            if (win_len == 0 || pre_len > PRE_DEPTH || pre_len > rec_index) begin
              add_due('0, rec_index, OUT_INVALID, 1'b1);
              scan = FINISHED;
            end else begin
              take = (win_len < int'(pre_len) + 1) ? win_len : int'(pre_len) + 1;
              fin = 1'b1;
              tail_code = OUT_OK;
              scan = FINISHED;
              if (take != win_len) begin
                left = CAP_W'(win_len - take);
                if (last) begin
                  tail_code = OUT_INSUF;
                end else begin
                  fin = 1'b0;
                  scan = CAPTURING;
                end
              end
              // Window head: pretrigger history, oldest first, then this sample.
              for (int k = 0; k < take; k++) begin
                slot = (int'(wr_ptr) + PRE_DEPTH - int'(pre_len) + k) % PRE_DEPTH;
                add_due((k < pre_len) ? history[slot] : s, rec_index,
                        (k == take - 1) ? tail_code : OUT_OK, (k == take - 1) && fin);
              end
            end
          end else if (last) begin
            add_due('0, '0, OUT_NOTRIG, 1'b1);
            scan = FINISHED;
          end
        end
        CAPTURING: begin
          if (left != 0) left = left - 1'b1;
          if (left == 0) begin
            add_due(s, trig_index, OUT_OK, 1'b1);
            scan = FINISHED;
          end else if (last) begin
            add_due(s, trig_index, OUT_INSUF, 1'b1);
            scan = FINISHED;
          end else begin
            add_due(s, trig_index, OUT_OK, 1'b0);
          end
        end
        default: ;
      endcase
      history[wr_ptr] = s;
      wr_ptr = wr_ptr + 1'b1;
      if (rec_index != INDEX_MAX) rec_index = rec_index + 1'b1;
      return 1'b1;
    endfunction

    task flag_mismatch(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Compares one delivered result with the oldest one owed.
    task check_result(logic [SAMPLE_W-1:0] smp, logic [INDEX_W-1:0] pos,
                      logic [OC_W-1:0] code, logic fin);
      window_item_t want;
      checked++;
      if (due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result sample %0d position %0d outcome %0d",
                                smp, pos, code));
        return;
      end
      want = due.pop_front();
      if (smp !== want.sample)
        flag_mismatch($sformatf("captured_sample %0d, want %0d", smp, want.sample));
      if (pos !== want.position)
        flag_mismatch($sformatf("trigger_position %0d, want %0d", pos, want.position));
      if (code !== want.code)
        flag_mismatch($sformatf("outcome %0d, want %0d", code, want.code));
      if (fin !== want.run_end)
        flag_mismatch($sformatf("end_of_run %0b, want %0b", fin, want.run_end));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  sample_value = '0;
  logic                 record_first = 1'b0;
  logic                 record_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SAMPLE_W-1:0]  captured_sample;
  logic [INDEX_W-1:0]   trigger_position;
  logic [OC_W-1:0]      outcome;
  logic                 end_of_run;

  capture_checker sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int settings_used = 0;
  int idle_plan [4] = '{0, 60, 0, 10};
  int stall_plan [4] = '{0, 0, 60, 10};

  hysteresis_trigger_capture i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .sample_value     (sample_value),
    .record_first     (record_first),
    .record_last      (record_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .captured_sample  (captured_sample),
    .trigger_position (trigger_position),
    .outcome          (outcome),
    .end_of_run       (end_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: check accepted results, then choose the next stall. A long
  // hold-off, once requested, is counted down here.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result(captured_sample, trigger_position, outcome, end_of_run);
      if (hold_left == 0 && hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offers one sample request, idling first at the current rate.
  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input logic f, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= v;
    record_first <= f;
    record_last <= l;
    do @(posedge clk); while (in_stall);
    void'(sb.take_sample(v, f, l));
  endtask

  // Waits until every owed result is in and the block has gone quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  // Rewrites every register once the block is idle.
  task automatic configure(input logic [SAMPLE_W-1:0] lvl, input logic [SAMPLE_W-1:0] hw,
                           input logic [MODE_W-1:0] md, input logic [INDEX_W-1:0] ofs,
                           input logic [PRE_W-1:0] pre, input logic [CAP_W-1:0] cap);
    wait_idle();
    write_reg(REG_LEVEL, lvl);
    write_reg(REG_HYST, hw);
    write_reg(REG_MODE, SAMPLE_W'(md));
    write_reg(REG_OFFSET, ofs);
    write_reg(REG_PRETRIG, SAMPLE_W'(pre));
    write_reg(REG_CAPTURE, SAMPLE_W'(cap));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Samples aimed at the current bands, so that arming and triggers are common.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] lo, hi;
    sb.band(lo, hi);
    case ($urandom_range(0, 9))
      0, 1, 2: return SAMPLE_W'($urandom_range(0, lo));
      3, 4, 5: return SAMPLE_W'($urandom_range(hi, SAMPLE_MAX));
      6, 7:    return SAMPLE_W'($urandom_range(lo, hi));
      8:       return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      default: return $urandom_range(0, 1) ? SAMPLE_MAX : '0;
    endcase
  endfunction

  // One record; a broken one has its first and last marks flipped at random.
  task automatic send_record(input bit clean);
    int bound, len;
    logic f, l;
    bound = int'(sb.arm_index) + int'(sb.pre_len) + 16;
    if (bound > 60) bound = 60;
    len = $urandom_range(1, bound);
    for (int k = 0; k < len; k++) begin
      f = (k == 0);
      l = (k == len - 1);
      if (!clean) begin
        f = f ^ ($urandom_range(0, 9) == 0);
        l = l ^ ($urandom_range(0, 9) == 0);
      end
      send_sample(pick_sample(), f, l);
    end
  endtask

  task automatic pick_setting();
    logic [SAMPLE_W-1:0] lvl, hw;
    logic [MODE_W-1:0]   md;
    logic [INDEX_W-1:0]  ofs;
    logic [PRE_W-1:0]    pre;
    logic [CAP_W-1:0]    cap;
    case ($urandom_range(0, 9))
      0:       lvl = '0;
      1:       lvl = SAMPLE_MAX;
      default: lvl = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    endcase
    case ($urandom_range(0, 9))
      0, 1:    hw = '0;
      2:       hw = SAMPLE_MAX;
      3, 4:    hw = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      default: hw = SAMPLE_W'($urandom_range(0, 3000));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: md = EDGE_RISE;
      3, 4, 5: md = EDGE_FALL;
      6, 7, 8: md = EDGE_EITHER;
      default: md = EDGE_UNUSED;
    endcase
    case ($urandom_range(0, 9))
      7, 8:    ofs = INDEX_W'($urandom_range(6, 40));
      9:       ofs = INDEX_MAX;
      default: ofs = INDEX_W'($urandom_range(0, 5));
    endcase
    case ($urandom_range(0, 9))
      6:       pre = PRE_W'($urandom_range(9, PRE_DEPTH - 1));
      7:       pre = PRE_W'(PRE_DEPTH);
      8:       pre = PRE_W'($urandom_range(PRE_DEPTH + 1, (1 << PRE_W) - 1));
      9:       pre = '0;
      default: pre = PRE_W'($urandom_range(0, 8));
    endcase
    case ($urandom_range(0, 9))
      6:       cap = CAP_W'($urandom_range(13, 40));
      7:       cap = '0;
      8:       cap = CAP_W'($urandom_range(MAX_CAPTURE, (1 << CAP_W) - 1));
      9:       cap = 13'd1;
      default: cap = CAP_W'($urandom_range(1, 12));
    endcase
    configure(lvl, hw, md, ofs, pre, cap);
  endtask

  initial begin
    int start_count;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: bands 900..1100, both edges, two pretrigger samples.
    configure(16'd1000, 16'd100, EDGE_EITHER, 16'd0, 6'd2, 13'd4);
    // A record that began at reset; trigger too early for the pretrigger.
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0, 1'b1);
    // Complete window, then a sample ignored after the run ends.
    send_sample(16'd0, 1'b1, 1'b0);
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0, 1'b0);
    send_sample(16'd7, 1'b0, 1'b0);
    send_sample(16'd9, 1'b0, 1'b1);
    // No trigger before the record ends.
    send_sample(16'd500, 1'b1, 1'b0);
    send_sample(16'd600, 1'b0, 1'b0);
    send_sample(16'd700, 1'b0, 1'b1);
    // Record ends at the trigger sample, so the window is cut short.
    send_sample(16'd0, 1'b1, 1'b0);
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0, 1'b1);
    // Falling edge.
    configure(16'd1000, 16'd100, EDGE_FALL, 16'd0, 6'd1, 13'd3);
    send_sample(SAMPLE_MAX, 1'b1, 1'b0);
    send_sample(16'd1000, 1'b0, 1'b0);
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(16'd5, 1'b0, 1'b1);
    // The unused edge mode never fires.
    configure(16'd1000, 16'd100, EDGE_UNUSED, 16'd0, 6'd0, 13'd4);
    send_sample(16'd0, 1'b1, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0, 1'b0);
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0, 1'b1);
    // Record shorter than the arming index.
    configure(16'd1000, 16'd100, EDGE_RISE, INDEX_MAX, 6'd0, 13'd4);
    send_sample(16'd1, 1'b1, 1'b0);
    send_sample(16'd2, 1'b0, 1'b1);
    // Bands at both extremes, one-sample window.
    configure(SAMPLE_MAX, SAMPLE_MAX, EDGE_EITHER, 16'd0, 6'd0, 13'd1);
    send_sample(16'd0, 1'b1, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0, 1'b1);

    // Full-depth window while the result side holds off: the sender keeps
    // offering the rest of the record, so the request queue fills and the
    // input stalls.
    configure(16'd1000, 16'd0, EDGE_RISE, 16'd0, PRE_W'(PRE_DEPTH), 13'd40);
    hold_request = 300;
    for (int k = 0; k < 40; k++)
      send_sample(SAMPLE_W'($urandom_range(0, 999)), k == 0, 1'b0);
    send_sample(SAMPLE_W'($urandom_range(1000, SAMPLE_MAX)), 1'b0, 1'b0);
    for (int k = 0; k < 7; k++) send_sample(pick_sample(), 1'b0, k == 6);

    // Random records under each idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      stall_pct = stall_plan[ph];
      start_count = sb.samples_taken;
      while (sb.samples_taken - start_count < PHASE_SAMPLES) begin
        pick_setting();
        repeat (3) send_record($urandom_range(0, 4) != 0);
      end
      if (ph == 0) begin
        // Oversized capture length; the record ends before the window does.
        configure(16'd1000, 16'd0, EDGE_RISE, 16'd0, 6'd3, 13'h1fff);
        for (int k = 0; k < 4; k++)
          send_sample(SAMPLE_W'($urandom_range(0, 999)), k == 0, 1'b0);
        send_sample(16'd1000, 1'b0, 1'b0);
        for (int k = 0; k < 6; k++)
          send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), 1'b0, k == 5);
      end
    end

    wait_idle();
    $display("Covered %0d samples and %0d results under %0d register settings.",
             sb.samples_taken, sb.checked, settings_used);
    $display("Runs ended: %0d complete, %0d no trigger, %0d invalid, %0d cut short.",
             sb.outcome_count[OUT_OK], sb.outcome_count[OUT_NOTRIG],
             sb.outcome_count[OUT_INVALID], sb.outcome_count[OUT_INSUF]);
    if (sb.errors == 0 && sb.due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
sv/htc_pkg.sv
sv/htc_front.sv
sv/htc_queue.sv
sv/htc_back.sv
sv/hysteresis_trigger_capture.sv
tb/hysteresis_trigger_capture_test.sv
